### src/sacache_pkg.sv
`default_nettype none
package sacache_pkg;

  localparam int SET_COUNT_DEF    = 64;
  localparam int WAYS_DEF         = 4;
  localparam int BLOCK_BYTES_DEF  = 16;
  localparam int ADDRESS_BITS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_BAD   = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    KIND_READ = 3'd0,
    KIND_DONE = 3'd1,
    KIND_WB   = 3'd2,
    KIND_REQ  = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic  in_ready;
    logic  load;
    logic  scan_rd;
    logic  scan_cmp;
    logic  wb_rd;
    logic  cnt_inc;
    logic  invalidate;
    logic  fill_wr;
    logic  fill_done;
    logic  fin_go;
    logic  emit;
    kind_t kind;
    logic  last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic error;
    logic is_fill;
    logic fill_last;
    logic hit_now;
    logic scan_last;
    logic vic_dirty;
    logic cnt_last;
    logic is_write;
  } ctrl_sts_t;

endpackage
`default_nettype wire

### src/sacache_if.sv
`default_nettype none
interface sacache_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] address;
  logic [7:0]  write_value;
  logic [7:0]  fill_value;
  modport source (output valid, command, address, write_value, fill_value, input ready);
  modport sink (input valid, command, address, write_value, fill_value, output ready);
endinterface

interface sacache_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] out_address;
  logic [7:0]  out_data;
  logic        hit;
  logic        last;
  modport source (output valid, kind, out_address, out_data, hit, last, input ready);
  modport sink (input valid, kind, out_address, out_data, hit, last, output ready);
endinterface
`default_nettype wire

### src/sacache_ctrl.sv
`default_nettype none
module sacache_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  output sacache_pkg::ctrl_cmd_t cmd,
  input  sacache_pkg::ctrl_sts_t sts
);
  import sacache_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_VICTIM,
    ST_WB_RD,
    ST_WB_OUT,
    ST_INVAL,
    ST_REQ,
    ST_FIN,
    ST_FIN_OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.error) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_ERR;
            cmd.last = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (sts.is_fill) begin
          cmd.fill_wr = 1'b1;
          if (sts.fill_last) begin
            cmd.fill_done = 1'b1;
            state_next = ST_FIN;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.hit_now) state_next = ST_FIN;
        else if (sts.scan_last) state_next = ST_VICTIM;
        else state_next = ST_SCAN_RD;
      end
      ST_VICTIM: begin
        state_next = sts.vic_dirty ? ST_WB_RD : ST_INVAL;
      end
      ST_WB_RD: begin
        cmd.wb_rd = 1'b1;
        state_next = ST_WB_OUT;
      end
      ST_WB_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_WB;
          cmd.cnt_inc = 1'b1;
          state_next = sts.cnt_last ? ST_INVAL : ST_WB_RD;
        end
      end
      ST_INVAL: begin
        cmd.invalidate = 1'b1;
        state_next = ST_REQ;
      end
      ST_REQ: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_REQ;
          cmd.last = sts.cnt_last;
          cmd.cnt_inc = 1'b1;
          if (sts.cnt_last) state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        cmd.fin_go = 1'b1;
        state_next = ST_FIN_OUT;
      end
      ST_FIN_OUT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = sts.is_write ? KIND_DONE : KIND_READ;
          cmd.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### src/sacache_dp.sv
`default_nettype none
module sacache_dp #(
  parameter int SET_COUNT    = sacache_pkg::SET_COUNT_DEF,
  parameter int WAYS         = sacache_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES  = sacache_pkg::BLOCK_BYTES_DEF,
  parameter int ADDRESS_BITS = sacache_pkg::ADDRESS_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  sacache_req_if.sink            req,
  sacache_rsp_if.source          rsp,
  input  sacache_pkg::ctrl_cmd_t cmd,
  output sacache_pkg::ctrl_sts_t sts
);
  import sacache_pkg::*;

  localparam int AW    = ADDRESS_BITS;
  localparam int LB    = $clog2(BLOCK_BYTES);
  localparam int LS    = $clog2(SET_COUNT);
  localparam int OW    = (LB > 0) ? LB : 1;
  localparam int SW    = (LS > 0) ? LS : 1;
  localparam int TB    = AW - LB - LS;
  localparam int TW    = (TB > 0) ? TB : 1;
  localparam int LINES = SET_COUNT * WAYS;
  localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DEPTH = LINES * BLOCK_BYTES;
  localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SPAN  = BLOCK_BYTES * SET_COUNT;

  function automatic logic [OW-1:0] off_of(input logic [AW-1:0] a);
    return OW'(a % BLOCK_BYTES);
  endfunction

  function automatic logic [SW-1:0] set_of(input logic [AW-1:0] a);
    return SW'((a / BLOCK_BYTES) % SET_COUNT);
  endfunction

  function automatic logic [TW-1:0] tag_of(input logic [AW-1:0] a);
    return TW'(a / SPAN);
  endfunction

  function automatic logic [LW-1:0] line_of(input logic [SW-1:0] s, input logic [WW-1:0] w);
    return LW'(32'(s) * WAYS + 32'(w));
  endfunction

  function automatic logic [DW-1:0] byte_of(input logic [LW-1:0] l, input logic [OW-1:0] o);
    return DW'(32'(l) * BLOCK_BYTES + 32'(o));
  endfunction

  // memories
  logic [TW-1:0] tag_mem [LINES];
  logic [31:0]   use_mem [LINES];
  logic [7:0]    data_mem [DEPTH];
  logic [LINES-1:0] valid, dirty;

  // access registers
  command_t      cmd_r;
  logic [AW-1:0] addr_r;
  logic [7:0]    wv_r, fv_r;
  logic          acc_write;
  logic          hit_r;

  // scan
  logic [WW-1:0] way, fin_way, vic_way;
  logic          inv_found;
  logic [31:0]   best;
  logic [TW-1:0] vic_tag;
  logic [TW-1:0] tagq;
  logic [31:0]   useq;
  logic [7:0]    rdata;
  logic [OW-1:0] cnt;

  // pending miss
  logic          miss_pending;
  logic          pend_write;
  logic [AW-1:0] pend_addr;
  logic [7:0]    pend_value;
  logic [OW-1:0] fill_count;
  logic [WW-1:0] victim_way;

  logic [31:0]   use_counter;

  // output register
  logic        out_valid;
  kind_t       out_kind;
  logic [31:0] out_addr;
  logic [7:0]  out_data;
  logic        out_hit, out_last;

  logic [SW-1:0] set_a;
  logic [TW-1:0] tag_a;
  logic [OW-1:0] off_a;
  logic [LW-1:0] scan_line, fin_line, vic_line, fill_line;
  logic          scan_hit;
  logic [AW-1:0] wb_addr, rq_addr;
  logic          dm_we, dm_re;
  logic [DW-1:0] dm_waddr, dm_raddr;
  logic [7:0]    dm_wdata;
  logic [31:0]   em_addr;
  logic [7:0]    em_data;
  logic          em_hit;

  always_comb begin
    set_a     = set_of(addr_r);
    tag_a     = tag_of(addr_r);
    off_a     = off_of(addr_r);
    scan_line = line_of(set_a, way);
    fin_line  = line_of(set_a, fin_way);
    vic_line  = line_of(set_a, vic_way);
    fill_line = line_of(set_of(pend_addr), victim_way);
    scan_hit  = valid[scan_line] && (tagq == tag_a);
    wb_addr   = (AW'(vic_tag) << (LB + LS)) | (AW'(set_a) << LB) | AW'(cnt);
    rq_addr   = (AW'(addr_r >> LB) << LB) | AW'(cnt);
  end

  always_comb begin
    dm_we    = cmd.fill_wr || (cmd.fin_go && acc_write);
    dm_waddr = cmd.fill_wr ? byte_of(fill_line, fill_count) : byte_of(fin_line, off_a);
    dm_wdata = cmd.fill_wr ? fv_r : wv_r;
    dm_re    = cmd.wb_rd || (cmd.fin_go && !acc_write);
    dm_raddr = cmd.wb_rd ? byte_of(vic_line, cnt) : byte_of(fin_line, off_a);
  end

  always_ff @(posedge clk) begin
    if (dm_we) data_mem[dm_waddr] <= dm_wdata;
    if (dm_re) rdata <= data_mem[dm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_done) tag_mem[fill_line] <= tag_of(pend_addr);
    if (cmd.scan_rd) tagq <= tag_mem[scan_line];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_go) use_mem[fin_line] <= use_counter + 32'd1;
    if (cmd.scan_rd) useq <= use_mem[scan_line];
  end

  always_comb begin
    em_addr = '0;
    em_data = '0;
    em_hit  = 1'b0;
    case (cmd.kind) inside
      KIND_WB: begin
        em_addr = 32'(wb_addr);
        em_data = rdata;
      end
      KIND_REQ: em_addr = 32'(rq_addr);
      KIND_READ: begin
        em_data = rdata;
        em_hit  = hit_r;
      end
      KIND_DONE: em_hit = hit_r;
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= command_t'(req.command);
      addr_r    <= req.address[AW-1:0];
      wv_r      <= req.write_value;
      fv_r      <= req.fill_value;
      acc_write <= (command_t'(req.command) == CMD_WRITE);
      hit_r     <= 1'b0;
      way       <= '0;
      inv_found <= 1'b0;
      cnt       <= '0;
    end
    if (cmd.scan_cmp) begin
      if (scan_hit) begin
        hit_r   <= 1'b1;
        fin_way <= way;
      end
      // first invalid way wins, else smallest stamp with the lowest way on a tie
      if (!inv_found) begin
        if (!valid[scan_line]) begin
          inv_found <= 1'b1;
          vic_way   <= way;
        end else if (way == '0 || useq < best) begin
          best    <= useq;
          vic_way <= way;
          vic_tag <= tagq;
        end
      end
      way <= way + 1'b1;
    end
    if (cmd.cnt_inc) cnt <= cnt + 1'b1;
    if (cmd.invalidate) begin
      pend_write <= acc_write;
      pend_addr  <= addr_r;
      pend_value <= wv_r;
      victim_way <= vic_way;
      cnt        <= '0;
    end
    if (cmd.fill_done) begin
      addr_r    <= pend_addr;
      wv_r      <= pend_value;
      acc_write <= pend_write;
      fin_way   <= victim_way;
    end
    if (cmd.emit) begin
      out_kind <= cmd.kind;
      out_addr <= em_addr;
      out_data <= em_data;
      out_hit  <= em_hit;
      out_last <= cmd.last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      dirty        <= '0;
      miss_pending <= 1'b0;
      fill_count   <= '0;
      use_counter  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.invalidate) begin
        valid[vic_line] <= 1'b0;
        dirty[vic_line] <= 1'b0;
        miss_pending    <= 1'b1;
        fill_count      <= '0;
      end
      if (cmd.fill_done) begin
        fill_count       <= '0;
        miss_pending     <= 1'b0;
        valid[fill_line] <= 1'b1;
        dirty[fill_line] <= 1'b0;
      end else if (cmd.fill_wr) begin
        fill_count <= fill_count + 1'b1;
      end
      if (cmd.fin_go) begin
        use_counter <= use_counter + 32'd1;
        if (acc_write) dirty[fin_line] <= 1'b1;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.in_valid  = req.valid;
    sts.out_free  = !out_valid || rsp.ready;
    sts.error     = (cmd_r == CMD_BAD) || (cmd_r == CMD_FILL && !miss_pending) ||
                    (cmd_r != CMD_FILL && cmd_r != CMD_BAD && miss_pending);
    sts.is_fill   = (cmd_r == CMD_FILL);
    sts.fill_last = (fill_count == OW'(BLOCK_BYTES - 1));
    sts.hit_now   = scan_hit;
    sts.scan_last = (way == WW'(WAYS - 1));
    sts.vic_dirty = valid[vic_line] && dirty[vic_line];
    sts.cnt_last  = (cnt == OW'(BLOCK_BYTES - 1));
    sts.is_write  = acc_write;
  end

  assign req.ready       = cmd.in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.out_address = out_addr;
  assign rsp.out_data    = out_data;
  assign rsp.hit         = out_hit;
  assign rsp.last        = out_last;

endmodule
`default_nettype wire

### src/set_assoc_write_back_lru_cache.sv
// Byte-wide set-associative write-back cache with LRU replacement. Commands on req are
// read, write, and fill (a byte returned by next memory); results on rsp are read data,
// write done, memory write requests, memory read requests and errors, with last marking
// the final result of each transaction. A hit probes the ways in order until the match:
// the tag and stamp memories have one read port and the controller probes one way at a
// time, reading and then comparing. A miss probes all ways, writes a dirty victim back
// one byte at a time, each byte read before it is sent, issues one read request per cycle
// while rsp accepts them and then takes BLOCK_BYTES fill transactions, the last of which
// finishes the access. A stalled rsp holds the block. Sizes of sets and blocks must be
// powers of two; the block itself does not enforce this.
`default_nettype none
module set_assoc_write_back_lru_cache #(
  parameter int SET_COUNT    = sacache_pkg::SET_COUNT_DEF,
  parameter int WAYS         = sacache_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES  = sacache_pkg::BLOCK_BYTES_DEF,
  parameter int ADDRESS_BITS = sacache_pkg::ADDRESS_BITS_DEF
) (
  input wire            clk,
  input wire            rst,
  sacache_req_if.sink   req,
  sacache_rsp_if.source rsp
);
  import sacache_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sacache_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  sacache_dp #(
    .SET_COUNT    (SET_COUNT),
    .WAYS         (WAYS),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule
`default_nettype wire

### src/sacache_checker.sv
`default_nettype none
module sacache_checker (
  input wire       clk,
  input wire       rst,
  input wire       rsp_valid,
  input wire       rsp_ready,
  input wire [2:0] rsp_kind,
  input wire       rsp_hit,
  input wire       rsp_last
);
  import sacache_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
    else $error("stalled result changed");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_ERR |-> rsp_last && !rsp_hit)
    else $error("error result not a single last transaction");

  a_wb_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_WB |-> !rsp_last)
    else $error("write-back ended a transaction");

  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> rsp_kind == KIND_READ || rsp_kind == KIND_DONE)
    else $error("hit flag on a request or error");

endmodule

bind set_assoc_write_back_lru_cache sacache_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_kind  (rsp.kind),
  .rsp_hit   (rsp.hit),
  .rsp_last  (rsp.last)
);
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;
  import sacache_pkg::*;

  localparam int NSETS = SET_COUNT_DEF;
  localparam int NWAYS = WAYS_DEF;
  localparam int BLK = BLOCK_BYTES_DEF;
  localparam int LIMIT = 600000;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        hit;
    logic        last;
  } cache_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  sacache_req_if req ();
  sacache_rsp_if rsp ();

  set_assoc_write_back_lru_cache uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // mirror of the cache contents
  logic [21:0] tag_mem [NSETS*NWAYS];
  logic        vld_mem [NSETS*NWAYS];
  logic        drt_mem [NSETS*NWAYS];
  logic [31:0] stamp_mem [NSETS*NWAYS];
  logic [7:0]  byte_mem [NSETS*NWAYS][BLK];
  logic [31:0] use_cnt;
  logic        pend;
  logic        pend_wr;
  logic [31:0] pend_addr;
  logic [7:0]  pend_val;
  int          fills_got;
  int          vic_way;

  cache_rsp_t expected_rsp [$];
  int   errors = 0;
  int   cycles = 0;
  logic calm = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void push_rsp(kind_t k, logic [31:0] a, logic [7:0] d, logic h);
    cache_rsp_t r;
    r.kind = k; r.addr = a; r.data = d; r.hit = h; r.last = 1'b0;
    expected_rsp.push_back(r);
  endfunction

  function automatic void complete(int line, logic wr, int off, logic [7:0] v, logic h);
    use_cnt = use_cnt + 1;
    stamp_mem[line] = use_cnt;
    if (wr) begin
      byte_mem[line][off] = v;
      drt_mem[line] = 1'b1;
      push_rsp(KIND_DONE, 32'd0, 8'd0, h);
    end else begin
      push_rsp(KIND_READ, 32'd0, byte_mem[line][off], h);
    end
  endfunction

  function automatic void predict_cache(logic [1:0] cmd, logic [31:0] a, logic [7:0] wv,
                                        logic [7:0] fv);
    int set, off, line, w, v, n0;
    logic [21:0] tg;
    logic [31:0] best, base;
    logic found;
    n0 = expected_rsp.size();
    set = a[9:4];
    off = a[3:0];
    tg = a[31:10];
    found = 1'b0;
    if (cmd == CMD_BAD || (cmd == CMD_FILL && !pend) || (cmd != CMD_FILL && cmd != CMD_BAD && pend))
      begin
      push_rsp(KIND_ERR, 32'd0, 8'd0, 1'b0);
    end else if (cmd == CMD_FILL) begin
      line = pend_addr[9:4] * NWAYS + vic_way;
      byte_mem[line][fills_got] = fv;
      fills_got++;
      if (fills_got == BLK) begin
        fills_got = 0;
        pend = 1'b0;
        vld_mem[line] = 1'b1;
        drt_mem[line] = 1'b0;
        tag_mem[line] = pend_addr[31:10];
        complete(line, pend_wr, pend_addr[3:0], pend_val, 1'b0);
      end
    end else begin
      for (w = 0; w < NWAYS && !found; w++) begin
        line = set * NWAYS + w;
        if (vld_mem[line] && tag_mem[line] == tg) begin
          complete(line, cmd == CMD_WRITE, off, wv, 1'b1);
          found = 1'b1;
        end
      end
      if (!found) begin
        v = -1;
        best = 0;
        for (w = 0; w < NWAYS && v < 0; w++)
          if (!vld_mem[set*NWAYS+w]) v = w;
        if (v < 0) begin
          for (w = 0; w < NWAYS; w++)
            if (w == 0 || stamp_mem[set*NWAYS+w] < best) begin
              best = stamp_mem[set*NWAYS+w];
              v = w;
            end
        end
        line = set * NWAYS + v;
        if (vld_mem[line] && drt_mem[line]) begin
          base = {tag_mem[line], set[5:0], 4'd0};
          for (w = 0; w < BLK; w++)
            push_rsp(KIND_WB, base + w, byte_mem[line][w], 1'b0);
        end
        vld_mem[line] = 1'b0;
        drt_mem[line] = 1'b0;
        tag_mem[line] = '0;
        for (w = 0; w < BLK; w++)
          push_rsp(KIND_REQ, {a[31:4], 4'd0} + w, 8'd0, 1'b0);
        pend = 1'b1;
        pend_wr = (cmd == CMD_WRITE);
        pend_addr = a;
        pend_val = wv;
        fills_got = 0;
        vic_way = v;
      end
    end
    // fills before the last one give no result
    if (expected_rsp.size() > n0) expected_rsp[$].last = 1'b1;
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [31:0] a, logic [7:0] wv, logic [7:0] fv);
    if (!calm && $urandom_range(99) < 29) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 29);
    end
    req.valid <= 1'b1;
    req.command <= cmd;
    req.address <= a;
    req.write_value <= wv;
    req.fill_value <= fv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_cache(cmd, a, wv, fv);
  endtask

  // access followed by the fill bytes of a miss
  task automatic access_with_fill(logic [1:0] cmd, logic [31:0] a, logic [7:0] wv);
    int i;
    send_item(cmd, a, wv, 8'($urandom));
    if (pend) begin
      for (i = 0; i < BLK; i++) send_item(CMD_FILL, 32'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_basic_hit_miss();
    access_with_fill(CMD_WRITE, 32'h0000_0000, 8'hff);
    access_with_fill(CMD_READ, 32'h0000_0000, 8'h00);
    access_with_fill(CMD_READ, 32'hffff_ffff, 8'h00);
    access_with_fill(CMD_WRITE, 32'hffff_ffff, 8'h00);
    access_with_fill(CMD_READ, 32'hffff_fff0, 8'hff);
  endtask

  task automatic test_errors();
    send_item(CMD_FILL, 32'h0, 8'h0, 8'h55);
    send_item(CMD_BAD, 32'hffff_ffff, 8'hff, 8'hff);
    send_item(CMD_READ, 32'h1234_5670, 8'h0, 8'h0);
    send_item(CMD_WRITE, 32'h0, 8'h11, 8'h0);
    send_item(CMD_READ, 32'h0, 8'h0, 8'h0);
    send_item(CMD_BAD, 32'h0, 8'h0, 8'h0);
    while (pend) send_item(CMD_FILL, 32'h0, 8'h0, 8'($urandom));
  endtask

  // five tags in set 3 force an lru eviction with write back
  task automatic test_lru_evict();
    int i;
    for (i = 0; i < 5; i++)
      access_with_fill(CMD_WRITE, (32'(i) << 10) | 32'h35, 8'(8'ha0 + i));
    access_with_fill(CMD_READ, 32'h35, 8'h0);
  endtask

  task automatic test_random(int n);
    int i, r;
    logic [31:0] a;
    for (i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 3 + 5);
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) a = $urandom;
      else a = {20'($urandom_range(5)), 2'($urandom), 6'($urandom_range(3)), 4'($urandom)};
      if (r < 88) begin
        access_with_fill(2'($urandom_range(1)), a, 8'($urandom));
      end else if (r < 93) begin
        send_item(2'($urandom), a, 8'($urandom), 8'($urandom));
        while (pend) begin
          if ($urandom_range(9) == 0) send_item(2'($urandom_range(1)), a, 8'($urandom), 8'h0);
          else send_item(CMD_FILL, a, 8'($urandom), 8'($urandom));
        end
      end else begin
        send_item(CMD_BAD, a, 8'($urandom), 8'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= calm || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    cache_rsp_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected transaction kind=%0d addr=%h data=%h hit=%b last=%b",
                 $time, rsp.kind, rsp.out_address, rsp.out_data, rsp.hit, rsp.last);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp.kind !== e.kind || rsp.out_address !== e.addr || rsp.out_data !== e.data ||
            rsp.hit !== e.hit || rsp.last !== e.last) begin
          $display("%0t: mismatch expected kind=%0d addr=%h data=%h hit=%b last=%b", $time,
                   e.kind, e.addr, e.data, e.hit, e.last);
          $display("%0t:          actual kind=%0d addr=%h data=%h hit=%b last=%b", $time,
                   rsp.kind, rsp.out_address, rsp.out_data, rsp.hit, rsp.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int i;
    req.valid = 1'b0;
    req.command = CMD_READ;
    req.address = '0;
    req.write_value = '0;
    req.fill_value = '0;
    for (i = 0; i < NSETS*NWAYS; i++) begin
      tag_mem[i] = '0; vld_mem[i] = 1'b0; drt_mem[i] = 1'b0; stamp_mem[i] = '0;
    end
    use_cnt = '0; pend = 1'b0; pend_wr = 1'b0; pend_addr = '0; pend_val = '0;
    fills_got = 0; vic_way = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_hit_miss();
    test_errors();
    test_lru_evict();
    test_random(24);
    @(posedge clk);
    req.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
src/sacache_pkg.sv
src/sacache_if.sv
src/sacache_ctrl.sv
src/sacache_dp.sv
src/set_assoc_write_back_lru_cache.sv
src/sacache_checker.sv
verif/tb.sv
